[rtl/core/cecd_pkg.sv]
// shared constants and types of the contour edge crossing detector
// no dependencies; used by every file in rtl/core
package cecd_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int FRAC_BITS     = 8;
  localparam int MAX_ROW_WIDTH = 4096;
  localparam int MIN_ROW_WIDTH = 2;
  localparam int COL_BITS      = $clog2(MAX_ROW_WIDTH);
  localparam int WIDTH_BITS    = COL_BITS + 1;
  localparam int QUOT_BITS     = FRAC_BITS + 1;
  localparam int DIV_CNT_BITS  = $clog2(QUOT_BITS + 1);
  localparam int ROW_LIMIT     = (1 << COL_BITS) - 1;
  localparam int CFG_IDX_BITS  = 1;
  localparam int RESET_ROW_WIDTH = 640;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CONTOUR_LEVEL = 1'b0,
    REG_ROW_WIDTH     = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_HDIV,
    ST_VDIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic                          missing;
    logic signed [SAMPLE_BITS-1:0] val;
  } pix_t;

endpackage

[rtl/core/cecd_div.sv]
// bit-serial restoring divider, one quotient bit per cycle
// depends on cecd_pkg
module cecd_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [cecd_pkg::SAMPLE_BITS-1:0]   num_i,
  input  logic [cecd_pkg::SAMPLE_BITS-1:0]   den_i,
  output logic                               done_o,
  output logic [cecd_pkg::QUOT_BITS-1:0]     quot_o
);

  logic [cecd_pkg::SAMPLE_BITS:0]     rem_q, rem_d;
  logic [cecd_pkg::SAMPLE_BITS-1:0]   den_q;
  logic [cecd_pkg::QUOT_BITS-1:0]     quot_q, quot_d;
  logic [cecd_pkg::DIV_CNT_BITS-1:0]  cnt_q, cnt_d;
  logic                               done_q;
  logic [cecd_pkg::SAMPLE_BITS+1:0]   diff;
  logic                               ge;

  assign diff = {1'b0, rem_q} - {2'b00, den_q};
  assign ge   = ~diff[cecd_pkg::SAMPLE_BITS+1];

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    if (cnt_q != '0) begin
      // remainder stays below the divisor after a step, so the shift fits
      rem_d  = {(ge ? diff[cecd_pkg::SAMPLE_BITS-1:0] : rem_q[cecd_pkg::SAMPLE_BITS-1:0]), 1'b0};
      quot_d = {quot_q[cecd_pkg::QUOT_BITS-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= cecd_pkg::DIV_CNT_BITS'(cecd_pkg::QUOT_BITS);
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= (cnt_q == cecd_pkg::DIV_CNT_BITS'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {1'b0, num_i};
      den_q  <= den_i;
      quot_q <= '0;
    end else begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

[rtl/core/contour_edge_crossing_detect_unit.sv]
// channel  | handshake                  | payload
// in       | in_valid_i / in_stall_o    | sample_value_i, sample_missing_i, frame_start_i
// out      | out_valid_o / out_stall_i  | pixel_col_o .. vert_frac_o
// cfg      | cfg_we_i                   | cfg_index_i, cfg_data_i
//
// each item is fetched from the line buffer, then passes two 9-bit serial divisions on
// the shared cecd_div, then the result is loaded; the input stays stalled until the
// result is loaded. rst_ni clears control state and counters; the line buffer is not
// cleared. a stalled output holds its item and the block waits before loading.
// depends on cecd_pkg and cecd_div
module contour_edge_crossing_detect_unit (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_we_i,
  input  logic [cecd_pkg::CFG_IDX_BITS-1:0]        cfg_index_i,
  input  logic [cecd_pkg::SAMPLE_BITS-1:0]         cfg_data_i,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic signed [cecd_pkg::SAMPLE_BITS-1:0]  sample_value_i,
  input  logic                                     sample_missing_i,
  input  logic                                     frame_start_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic [cecd_pkg::COL_BITS-1:0]            pixel_col_o,
  output logic [cecd_pkg::COL_BITS-1:0]            pixel_row_o,
  output logic                                     horiz_cross_o,
  output logic [cecd_pkg::QUOT_BITS-1:0]           horiz_frac_o,
  output logic                                     vert_cross_o,
  output logic [cecd_pkg::QUOT_BITS-1:0]           vert_frac_o
);

  cecd_pkg::state_e state_q, state_d;

  logic signed [cecd_pkg::SAMPLE_BITS-1:0] level_q;
  logic [cecd_pkg::WIDTH_BITS-1:0]         row_width_q;
  logic [cecd_pkg::COL_BITS-1:0]           col_q, row_q;
  cecd_pkg::pix_t                          cur_q, left_q, upper_q;
  cecd_pkg::pix_t                          line_mem [cecd_pkg::MAX_ROW_WIDTH];
  logic                                    hcross_q, vcross_q;
  logic [cecd_pkg::QUOT_BITS-1:0]          hfrac_q;
  logic                                    out_valid_q;
  logic [cecd_pkg::COL_BITS-1:0]           res_col_q, res_row_q;
  logic                                    res_hc_q, res_vc_q;
  logic [cecd_pkg::QUOT_BITS-1:0]          res_hf_q, res_vf_q;

  logic                                    accept, div_start, div_done, out_load;
  logic [cecd_pkg::QUOT_BITS-1:0]          div_quot;
  logic [cecd_pkg::COL_BITS-1:0]           rd_addr;
  cecd_pkg::pix_t                          edge_a;
  logic                                    a_ge, cur_ge, left_ge, up_ge;
  logic signed [cecd_pkg::SAMPLE_BITS:0]   num_full, den_full;
  logic [cecd_pkg::WIDTH_BITS-1:0]         width_eff;
  logic                                    col_last;

  assign accept  = in_valid_i && !in_stall_o;
  assign rd_addr = frame_start_i ? '0 : col_q;

  // comparisons against the level, used for both edges
  assign cur_ge  = cur_q.val >= level_q;
  assign left_ge = left_q.val >= level_q;
  assign up_ge   = upper_q.val >= level_q;

  // the divider operands come from the left pixel first, then the upper one
  assign edge_a = (state_q == cecd_pkg::ST_FETCH) ? left_q : upper_q;
  assign a_ge   = edge_a.val >= level_q;

  always_comb begin
    if (a_ge) begin
      num_full = {edge_a.val[cecd_pkg::SAMPLE_BITS-1], edge_a.val}
               - {level_q[cecd_pkg::SAMPLE_BITS-1], level_q};
      den_full = {edge_a.val[cecd_pkg::SAMPLE_BITS-1], edge_a.val}
               - {cur_q.val[cecd_pkg::SAMPLE_BITS-1], cur_q.val};
    end else begin
      num_full = {level_q[cecd_pkg::SAMPLE_BITS-1], level_q}
               - {edge_a.val[cecd_pkg::SAMPLE_BITS-1], edge_a.val};
      den_full = {cur_q.val[cecd_pkg::SAMPLE_BITS-1], cur_q.val}
               - {edge_a.val[cecd_pkg::SAMPLE_BITS-1], edge_a.val};
    end
  end

  cecd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_full[cecd_pkg::SAMPLE_BITS-1:0]),
    .den_i   (den_full[cecd_pkg::SAMPLE_BITS-1:0]),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      cecd_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) state_d = cecd_pkg::ST_FETCH;
      end
      cecd_pkg::ST_FETCH: begin
        div_start = 1'b1;
        state_d   = cecd_pkg::ST_HDIV;
      end
      cecd_pkg::ST_HDIV: begin
        if (div_done) begin
          div_start = 1'b1;
          state_d   = cecd_pkg::ST_VDIV;
        end
      end
      cecd_pkg::ST_VDIV: begin
        if (div_done) state_d = cecd_pkg::ST_OUT;
      end
      cecd_pkg::ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = cecd_pkg::ST_IDLE;
        end
      end
      default: state_d = cecd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= cecd_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  // row width clamped into the supported range
  always_comb begin
    if (row_width_q < cecd_pkg::WIDTH_BITS'(cecd_pkg::MIN_ROW_WIDTH))
      width_eff = cecd_pkg::WIDTH_BITS'(cecd_pkg::MIN_ROW_WIDTH);
    else if (row_width_q > cecd_pkg::WIDTH_BITS'(cecd_pkg::MAX_ROW_WIDTH))
      width_eff = cecd_pkg::WIDTH_BITS'(cecd_pkg::MAX_ROW_WIDTH);
    else
      width_eff = row_width_q;
  end
  assign col_last = ({1'b0, col_q} + cecd_pkg::WIDTH_BITS'(1)) >= width_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= '0;
      row_width_q <= cecd_pkg::WIDTH_BITS'(cecd_pkg::RESET_ROW_WIDTH);
    end else if (cfg_we_i) begin
      case (cecd_pkg::cfg_reg_e'(cfg_index_i))
        cecd_pkg::REG_CONTOUR_LEVEL: level_q <= cfg_data_i;
        cecd_pkg::REG_ROW_WIDTH:     row_width_q <= cfg_data_i[cecd_pkg::WIDTH_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q          <= '0;
      row_q          <= '0;
      left_q.missing <= 1'b1;
      left_q.val     <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (accept && frame_start_i) begin
        col_q <= '0;
        row_q <= '0;
      end else if (out_load) begin
        left_q <= cur_q;
        if (col_last) begin
          col_q <= '0;
          if (row_q != cecd_pkg::COL_BITS'(cecd_pkg::ROW_LIMIT)) row_q <= row_q + 1'b1;
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
      if (out_load)                       out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // line buffer: read at accept, current sample written back in the following cycle
  always_ff @(posedge clk_i) begin
    if (accept) upper_q <= line_mem[rd_addr];
    if (state_q == cecd_pkg::ST_FETCH) line_mem[col_q] <= cur_q;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_q.val     <= sample_value_i;
      cur_q.missing <= sample_missing_i;
    end
    if (state_q == cecd_pkg::ST_FETCH) begin
      hcross_q <= (col_q != '0) && !left_q.missing && !cur_q.missing && (left_ge != cur_ge);
      vcross_q <= (row_q != '0) && !upper_q.missing && !cur_q.missing && (up_ge != cur_ge);
    end
    if (state_q == cecd_pkg::ST_HDIV && div_done) hfrac_q <= div_quot;
    if (out_load) begin
      res_col_q <= col_q;
      res_row_q <= row_q;
      res_hc_q  <= hcross_q;
      res_hf_q  <= hcross_q ? hfrac_q : '0;
      res_vc_q  <= vcross_q;
      res_vf_q  <= vcross_q ? div_quot : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_col_o   = res_col_q;
  assign pixel_row_o   = res_row_q;
  assign horiz_cross_o = res_hc_q;
  assign horiz_frac_o  = res_hf_q;
  assign vert_cross_o  = res_vc_q;
  assign vert_frac_o   = res_vf_q;

endmodule

[rtl/core/cecd_checker.sv]
// port-level checks of the contour edge crossing detector, bound to the top level
// depends on cecd_pkg and contour_edge_crossing_detect_unit
module cecd_checker (
  input logic                                     clk_i,
  input logic                                     rst_ni,
  input logic                                     cfg_we_i,
  input logic [cecd_pkg::CFG_IDX_BITS-1:0]        cfg_index_i,
  input logic [cecd_pkg::SAMPLE_BITS-1:0]         cfg_data_i,
  input logic                                     in_valid_i,
  input logic                                     in_stall_o,
  input logic signed [cecd_pkg::SAMPLE_BITS-1:0]  sample_value_i,
  input logic                                     sample_missing_i,
  input logic                                     frame_start_i,
  input logic                                     out_valid_o,
  input logic                                     out_stall_i,
  input logic [cecd_pkg::COL_BITS-1:0]            pixel_col_o,
  input logic [cecd_pkg::COL_BITS-1:0]            pixel_row_o,
  input logic                                     horiz_cross_o,
  input logic [cecd_pkg::QUOT_BITS-1:0]           horiz_frac_o,
  input logic                                     vert_cross_o,
  input logic [cecd_pkg::QUOT_BITS-1:0]           vert_frac_o
);

  // a stalled result keeps its place
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_col_o) && $stable(horiz_frac_o))
    else $error("stalled result changed");

  // one item at a time: the input closes right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pixel_col_o == '0 |-> !horiz_cross_o)
    else $error("horizontal crossing in first column");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pixel_row_o == '0 |-> !vert_cross_o)
    else $error("vertical crossing in first row");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (!horiz_cross_o || !vert_cross_o) |->
      (horiz_cross_o || horiz_frac_o == '0) && (vert_cross_o || vert_frac_o == '0))
    else $error("fraction without crossing");

endmodule

bind contour_edge_crossing_detect_unit cecd_checker u_cecd_checker (.*);
